// ----- rtl/core/smpd_pkg.sv -----
// ----------------------------------------------------------------------------
// Strided memory port device package
// Shared types, register codes and constants for the strided port device.
// ----------------------------------------------------------------------------
`default_nettype none

package smpd_pkg;

  // Default number of address bits of the extended memory.
  localparam int unsigned ADDR_BITS_DEF = 16;

  // Register and configuration widths.
  localparam int unsigned RES_BITS  = 10;
  localparam int unsigned CFG_IDX_W = 1;

  // Reset values of the resolution registers.
  localparam logic [RES_BITS-1:0] RES_WIDTH_RST  = 10'd320;
  localparam logic [RES_BITS-1:0] RES_HEIGHT_RST = 10'd200;

  // Flag masks and size limits.
  localparam logic [7:0]  FLAGS_MASK   = 8'hC3;
  localparam logic [7:0]  FLAGS_UPDATE = 8'h80;
  localparam logic [15:0] SIZE_MAX     = 16'hFFFF;
  localparam logic [15:0] LOW_BYTE     = 16'h00FF;
  localparam logic [15:0] HIGH_BYTE    = 16'hFF00;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RES_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RES_HEIGHT = 1'd1;

  // Access kinds.
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // Device register indexes.
  typedef enum logic [3:0] {
    REG_FLAGS    = 4'd0,
    REG_SIZE_HI  = 4'd1,
    REG_SIZE_LO  = 4'd2,
    REG_ADDR_HI  = 4'd3,
    REG_ADDR_LO  = 4'd4,
    REG_PITCH_HI = 4'd5,
    REG_PITCH_LO = 4'd6,
    REG_WIDTH_HI = 4'd7,
    REG_WIDTH_LO = 4'd8,
    REG_DATA     = 4'd9
  } reg_idx_e;

  // Memory access request for one item.
  typedef struct packed {
    logic        we;
    logic        re;
    logic [15:0] addr;
    logic [7:0]  wdata;
  } mem_req_t;

  // Result of one item before the memory data is merged in.
  typedef struct packed {
    logic       from_mem;
    logic [7:0] data;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/smpd_regs.sv -----
// ----------------------------------------------------------------------------
// Strided memory port device register file
// Holds the device registers, applies one access per cycle and issues the
// memory request for data port accesses.
// ----------------------------------------------------------------------------
`default_nettype none

module smpd_regs (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [smpd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [smpd_pkg::RES_BITS-1:0]       cfg_wdata_i,
  input  wire logic                                acc_i,
  input  wire logic                                kind_i,
  input  wire logic [3:0]                          reg_index_i,
  input  wire logic [7:0]                          wdata_i,
  output smpd_pkg::mem_req_t                       mem_req_o,
  output smpd_pkg::result_t                        result_o
);

  logic [smpd_pkg::RES_BITS-1:0] res_width_q, res_height_q;
  logic [15:0] addr_q, addr_d;
  logic [15:0] pitch_q, pitch_d;
  logic [15:0] width_q, width_d;
  logic [15:0] left_q, left_d;
  logic [7:0]  flags_q, flags_d;
  logic [15:0] size_q, size_d;

  logic                  is_write;
  smpd_pkg::reg_idx_e    idx;
  logic [19:0]           product;
  logic [16:0]           base;
  logic [15:0]           left_dec;
  logic [7:0]            new_flags;
  logic [15:0]           new_size;
  logic [1:0]            depth;
  logic [1:0]            cand;
  logic                  found;
  logic                  stepped;
  logic [18:0]           shifted;
  logic [7:0]            reg_byte;

  assign is_write = (kind_i == smpd_pkg::KIND_WRITE);
  assign idx      = smpd_pkg::reg_idx_e'(reg_index_i);

  // Buffer size base from the configured resolution.
  assign product = 20'(res_width_q) * 20'(res_height_q);
  assign base    = 17'(product >> 3);

  // Flags write: clamp to SIZE_MAX, else step down from the requested depth.
  always_comb begin
    new_flags = wdata_i & smpd_pkg::FLAGS_MASK;
    new_size  = size_q;
    depth     = 2'd0;
    found     = 1'b0;
    stepped   = 1'b0;
    cand      = 2'd0;
    shifted   = '0;
    if (wdata_i[7]) begin
      if (base > 17'(smpd_pkg::SIZE_MAX)) begin
        new_size  = smpd_pkg::SIZE_MAX;
        new_flags = smpd_pkg::FLAGS_UPDATE;
      end else begin
        for (int t = 0; t < 4; t++) begin
          cand    = wdata_i[1:0] - 2'(t);
          shifted = {2'b00, base} << cand;
          if (!found && (shifted[18:16] == 3'd0)) begin
            found   = 1'b1;
            depth   = cand;
            stepped = (t != 0);
          end
        end
        shifted  = {2'b00, base} << depth;
        new_size = shifted[15:0];
        if (stepped) begin
          new_flags = smpd_pkg::FLAGS_UPDATE | {6'd0, depth};
        end
      end
    end else begin
      new_size = size_q;
    end
  end

  assign left_dec = left_q - 16'd1;

  // Next register state for the accepted access.
  always_comb begin
    addr_d  = addr_q;
    pitch_d = pitch_q;
    width_d = width_q;
    left_d  = left_q;
    flags_d = flags_q;
    size_d  = size_q;
    if (acc_i && is_write) begin
      case (idx)
        smpd_pkg::REG_FLAGS: begin
          flags_d = new_flags;
          size_d  = new_size;
        end
        smpd_pkg::REG_SIZE_HI:  size_d  = (size_q & smpd_pkg::LOW_BYTE) | {wdata_i, 8'd0};
        smpd_pkg::REG_SIZE_LO:  size_d  = (size_q & smpd_pkg::HIGH_BYTE) | {8'd0, wdata_i};
        smpd_pkg::REG_ADDR_HI:  addr_d  = (addr_q & smpd_pkg::LOW_BYTE) | {wdata_i, 8'd0};
        smpd_pkg::REG_ADDR_LO:  addr_d  = (addr_q & smpd_pkg::HIGH_BYTE) | {8'd0, wdata_i};
        smpd_pkg::REG_PITCH_HI: pitch_d = (pitch_q & smpd_pkg::LOW_BYTE) | {wdata_i, 8'd0};
        smpd_pkg::REG_PITCH_LO: pitch_d = (pitch_q & smpd_pkg::HIGH_BYTE) | {8'd0, wdata_i};
        smpd_pkg::REG_WIDTH_HI: width_d = (width_q & smpd_pkg::LOW_BYTE) | {wdata_i, 8'd0};
        smpd_pkg::REG_WIDTH_LO: width_d = (width_q & smpd_pkg::HIGH_BYTE) | {8'd0, wdata_i};
        smpd_pkg::REG_DATA: begin
          // Advance, and skip to the next line at the end of a run.
          if (left_dec == 16'd0) begin
            left_d = width_q;
            addr_d = addr_q + 16'd1 + pitch_q - width_q;
          end else begin
            left_d = left_dec;
            addr_d = addr_q + 16'd1;
          end
        end
        default: ;
      endcase
      if (pitch_d == 16'd0) begin
        pitch_d = 16'd1;
      end
      if (width_d == 16'd0) begin
        width_d = 16'd1;
      end
      if ((idx == smpd_pkg::REG_ADDR_HI) || (idx == smpd_pkg::REG_ADDR_LO) ||
          (idx == smpd_pkg::REG_WIDTH_HI) || (idx == smpd_pkg::REG_WIDTH_LO)) begin
        left_d = width_d;
      end
    end
  end

  // Read-back byte from the state after the access.
  always_comb begin
    case (idx)
      smpd_pkg::REG_FLAGS:    reg_byte = flags_d;
      smpd_pkg::REG_SIZE_HI:  reg_byte = size_d[15:8];
      smpd_pkg::REG_SIZE_LO:  reg_byte = size_d[7:0];
      smpd_pkg::REG_ADDR_HI:  reg_byte = addr_d[15:8];
      smpd_pkg::REG_ADDR_LO:  reg_byte = addr_d[7:0];
      smpd_pkg::REG_PITCH_HI: reg_byte = pitch_d[15:8];
      smpd_pkg::REG_PITCH_LO: reg_byte = pitch_d[7:0];
      smpd_pkg::REG_WIDTH_HI: reg_byte = width_d[15:8];
      smpd_pkg::REG_WIDTH_LO: reg_byte = width_d[7:0];
      smpd_pkg::REG_DATA:     reg_byte = wdata_i;
      default:                reg_byte = 8'd0;
    endcase
  end

  // A data port read takes its byte from memory.
  assign result_o.from_mem = !is_write && (idx == smpd_pkg::REG_DATA);
  assign result_o.data     = reg_byte;

  // Memory request at the address before the access.
  assign mem_req_o.we    = acc_i && is_write && (idx == smpd_pkg::REG_DATA);
  assign mem_req_o.re    = acc_i && !is_write && (idx == smpd_pkg::REG_DATA);
  assign mem_req_o.addr  = addr_q;
  assign mem_req_o.wdata = wdata_i;

  // State registers and configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_width_q  <= smpd_pkg::RES_WIDTH_RST;
      res_height_q <= smpd_pkg::RES_HEIGHT_RST;
      addr_q       <= 16'd0;
      pitch_q      <= 16'd1;
      width_q      <= 16'd1;
      left_q       <= 16'd1;
      flags_q      <= 8'd0;
      size_q       <= 16'd0;
    end else begin
      if (cfg_we_i && (cfg_index_i == smpd_pkg::CFG_RES_WIDTH)) begin
        res_width_q <= cfg_wdata_i;
      end
      if (cfg_we_i && (cfg_index_i == smpd_pkg::CFG_RES_HEIGHT)) begin
        res_height_q <= cfg_wdata_i;
      end
      addr_q  <= addr_d;
      pitch_q <= pitch_d;
      width_q <= width_d;
      left_q  <= left_d;
      flags_q <= flags_d;
      size_q  <= size_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/smpd_mem.sv -----
// ----------------------------------------------------------------------------
// Strided memory port device extended memory
// Single-port byte memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module smpd_mem #(
  parameter int unsigned ADDR_BITS = smpd_pkg::ADDR_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire smpd_pkg::mem_req_t req_i,
  output logic [7:0]              rdata_o
);

  localparam int unsigned DEPTH = 1 << ADDR_BITS;

  logic [7:0]           mem [DEPTH];
  logic [ADDR_BITS-1:0] index;
  logic [7:0]           rdata_q;

  // The store is indexed by the low address bits.
  assign index = ADDR_BITS'(req_i.addr);

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[index] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[index];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/smpd_outq.sv -----
// ----------------------------------------------------------------------------
// Strided memory port device output queue
// Two-entry result queue that decouples the output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module smpd_outq (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire logic [7:0] push_data_i,
  output logic            full_o,
  output logic            valid_o,
  input  wire logic       ready_i,
  output logic [7:0]      data_o
);

  logic [1:0] cnt_q, cnt_d;
  logic [7:0] head_q, head_d;
  logic [7:0] tail_q, tail_d;
  logic       pop;
  logic [1:0] slot;

  assign pop = (cnt_q != 2'd0) && ready_i;

  // Shift on pop, then place the pushed item behind the remaining ones.
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    if (pop) begin
      head_d = tail_q;
    end
    slot  = cnt_q - {1'b0, pop};
    cnt_d = slot + {1'b0, push_i};
    if (push_i) begin
      if (slot == 2'd0) begin
        head_d = push_data_i;
      end else begin
        tail_d = push_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = head_q;

endmodule

`default_nettype wire

// ----- rtl/core/strided_memory_port_device_top.sv -----
// Results: each result passes through the result stage register and the output
// queue before it is offered on the output.
// Throughput: one item per cycle unless stalled; the extended memory's single
// port serves one data port access per cycle, and register updates finish in
// that cycle. Up to three results are held while the output is stalled.
// Reset: rst_ni is asynchronous and active low; state registers take their
// reset values at once; data registers and memory contents are undefined until written.
// ----------------------------------------------------------------------------
// Strided memory port device top level
// Byte-wide register device with a strided data port into extended memory.
// ----------------------------------------------------------------------------
`default_nettype none

module strided_memory_port_device_top #(
  parameter int unsigned ADDR_BITS = smpd_pkg::ADDR_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Configuration write port.
  input  wire logic                           cfg_we_i,
  input  wire logic [smpd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [smpd_pkg::RES_BITS-1:0]  cfg_wdata_i,
  // Access items.
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [15:0]                    s_axis_tdata,  // reg_index[3:0], wdata[11:4]
  input  wire logic                           s_axis_tuser,  // kind[0]
  // Result items.
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [7:0]                          m_axis_tdata   // rdata[7:0]
);

  logic               acc;
  smpd_pkg::mem_req_t mem_req;
  smpd_pkg::result_t  result;
  logic [7:0]         mem_rdata;
  logic               stage_v_q;
  logic               stage_mem_q;
  logic [7:0]         stage_byte_q;
  logic               stage_adv;
  logic               outq_full;

  assign stage_adv     = stage_v_q && !outq_full;
  assign s_axis_tready = !stage_v_q || stage_adv;
  assign acc           = s_axis_tvalid && s_axis_tready;

  smpd_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .acc_i       (acc),
    .kind_i      (s_axis_tuser),
    .reg_index_i (s_axis_tdata[3:0]),
    .wdata_i     (s_axis_tdata[11:4]),
    .mem_req_o   (mem_req),
    .result_o    (result)
  );

  smpd_mem #(
    .ADDR_BITS (ADDR_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // Result stage, waiting on the registered memory read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_v_q <= 1'b0;
    end else if (acc) begin
      stage_v_q <= 1'b1;
    end else if (stage_adv) begin
      stage_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      stage_mem_q  <= result.from_mem;
      stage_byte_q <= result.data;
    end
  end

  smpd_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (stage_adv),
    .push_data_i (stage_mem_q ? mem_rdata : stage_byte_q),
    .full_o      (outq_full),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .data_o      (m_axis_tdata)
  );

`ifndef SYNTHESIS
  // The memory port never reads and writes in the same cycle.
  a_mem_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req.we && mem_req.re))
    else $error("memory read and write issued together");

  // An accepted item always occupies the result stage next cycle.
  a_accept_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> stage_v_q)
    else $error("accepted item lost before the result stage");

  // No item is taken while the result stage cannot drain.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_v_q && outq_full) |-> !s_axis_tready)
    else $error("item accepted with result stage blocked");
`endif

endmodule

`default_nettype wire
